>>> design/dtno_pkg.sv
package dtno_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH    = 4;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_NUMBER      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_VELOCITY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANALOG_CHANNEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITAL_CHANNEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CC_ON_NUMBER     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CC_CHANNEL       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_DURATION_MS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS      = 3'd7;

  // register reset values
  localparam logic [6:0]  RST_NOTE_NUMBER      = 7'd60;
  localparam logic [6:0]  RST_NOTE_VELOCITY    = 7'd100;
  localparam logic [4:0]  RST_ANALOG_CHANNEL   = 5'd1;
  localparam logic [4:0]  RST_DIGITAL_CHANNEL  = 5'd2;
  localparam logic [6:0]  RST_CC_ON_NUMBER     = 7'd2;
  localparam logic [4:0]  RST_CC_CHANNEL       = 5'd16;
  localparam logic [15:0] RST_NOTE_DURATION_MS = 16'd5000;
  localparam logic [15:0] RST_DEBOUNCE_MS      = 16'd250;

  // message kinds
  localparam logic [1:0] KIND_ON  = 2'd0;
  localparam logic [1:0] KIND_OFF = 2'd1;
  localparam logic [1:0] KIND_CC  = 2'd2;

  localparam logic       ACTION_START = 1'b0;
  localparam logic [6:0] CC_VALUE     = 7'd1;

  typedef struct packed {
    logic [6:0]  note_number;
    logic [6:0]  note_velocity;
    logic [4:0]  analog_channel;
    logic [4:0]  digital_channel;
    logic [6:0]  cc_on_number;
    logic [4:0]  cc_channel;
    logic [15:0] note_duration_ms;
    logic [15:0] debounce_ms;
  } cfg_t;

  // burst that the front end hands to the back end
  typedef enum logic [1:0] {
    OP_START,
    OP_TRIGGER,
    OP_EXPIRE
  } op_t;

  // flag: START -> digital note active, TRIGGER -> analog off first,
  //       EXPIRE -> analog on at the end
  typedef struct packed {
    op_t  op;
    logic flag;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t desc;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> design/dtno_ifs.sv
interface dtno_in_if;
  logic valid;
  logic ready;
  logic action;
  logic pin_level;
  logic ms_tick;

  modport source (output valid, output action, output pin_level, output ms_tick,
                  input ready);
  modport sink   (input valid, input action, input pin_level, input ms_tick,
                  output ready);
endinterface

interface dtno_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] msg_kind;
  logic [4:0] msg_channel;
  logic [6:0] msg_number;
  logic [6:0] msg_value;
  logic       out_pin_level;
  logic       last_of_run;

  modport source (output valid, output msg_kind, output msg_channel, output msg_number,
                  output msg_value, output out_pin_level, output last_of_run,
                  input ready);
  modport sink   (input valid, input msg_kind, input msg_channel, input msg_number,
                  input msg_value, input out_pin_level, input last_of_run,
                  output ready);
endinterface

>>> design/dtno_front.sv
module dtno_front #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  dtno_in_if.sink             in_ch,
  input  dtno_pkg::cfg_t      cfg,
  input  dtno_pkg::q_stat_t   q_stat,
  output dtno_pkg::q_wr_t     q_wr
);

  localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  logic                   analog_r, analog_nxt;
  logic                   digital_r, digital_nxt;
  logic                   pending_r, pending_nxt;
  logic                   accepted_r, accepted_nxt;
  logic [TIMER_WIDTH-1:0] note_ms_r, note_ms_nxt;
  logic [TIMER_WIDTH-1:0] deb_ms_r, deb_ms_nxt;

  logic                   take;
  logic [TIMER_WIDTH-1:0] note_ms_t, deb_ms_t;
  logic                   note_done, deb_done;

  assign in_ch.ready = !q_stat.full;
  assign take        = in_ch.valid && in_ch.ready;

  // timers advance before the item is looked at
  always_comb begin
    note_ms_t = note_ms_r;
    deb_ms_t  = deb_ms_r;
    if (in_ch.ms_tick) begin
      if (note_ms_r != '1) note_ms_t = note_ms_r + 1'b1;
      if (deb_ms_r != '1)  deb_ms_t  = deb_ms_r + 1'b1;
    end
  end

  assign note_done = CW'(note_ms_t) >= CW'(cfg.note_duration_ms);
  assign deb_done  = CW'(deb_ms_t) >= CW'(cfg.debounce_ms);

  always_comb begin
    analog_nxt   = analog_r;
    digital_nxt  = digital_r;
    pending_nxt  = pending_r;
    accepted_nxt = accepted_r;
    note_ms_nxt  = note_ms_t;
    deb_ms_nxt   = deb_ms_t;
    q_wr.push    = 1'b0;
    q_wr.desc.op   = dtno_pkg::OP_START;
    q_wr.desc.flag = 1'b0;

    if (in_ch.action == dtno_pkg::ACTION_START) begin
      if (!analog_r) begin
        q_wr.push      = 1'b1;
        q_wr.desc.op   = dtno_pkg::OP_START;
        q_wr.desc.flag = digital_r;
        analog_nxt     = 1'b1;
      end
    end else begin
      if (digital_r && note_done) begin
        q_wr.push      = 1'b1;
        q_wr.desc.op   = dtno_pkg::OP_EXPIRE;
        q_wr.desc.flag = !analog_r;
        digital_nxt    = 1'b0;
        analog_nxt     = 1'b1;
        note_ms_nxt    = '0;
      end
      // no debounce can be pending right after an expiry
      if (!digital_nxt) begin
        if (pending_r) begin
          if (!in_ch.pin_level) begin
            pending_nxt = 1'b0;
          end else if (deb_done) begin
            pending_nxt    = 1'b0;
            accepted_nxt   = 1'b1;
            q_wr.push      = 1'b1;
            q_wr.desc.op   = dtno_pkg::OP_TRIGGER;
            q_wr.desc.flag = analog_nxt;
            analog_nxt     = 1'b0;
            digital_nxt    = 1'b1;
            note_ms_nxt    = '0;
          end
        end else if (in_ch.pin_level != accepted_r) begin
          if (in_ch.pin_level) begin
            pending_nxt = 1'b1;
            deb_ms_nxt  = '0;
          end else begin
            accepted_nxt = 1'b0;
          end
        end
      end
    end

    if (!take) begin
      analog_nxt   = analog_r;
      digital_nxt  = digital_r;
      pending_nxt  = pending_r;
      accepted_nxt = accepted_r;
      note_ms_nxt  = note_ms_r;
      deb_ms_nxt   = deb_ms_r;
      q_wr.push    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      analog_r   <= 1'b0;
      digital_r  <= 1'b0;
      pending_r  <= 1'b0;
      accepted_r <= 1'b0;
      note_ms_r  <= '0;
      deb_ms_r   <= '0;
    end else begin
      analog_r   <= analog_nxt;
      digital_r  <= digital_nxt;
      pending_r  <= pending_nxt;
      accepted_r <= accepted_nxt;
      note_ms_r  <= note_ms_nxt;
      deb_ms_r   <= deb_ms_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_stat.full)
    else $error("burst pushed into full queue");

  a_no_pending_digital: assert property (@(posedge clk) disable iff (!rst_n)
    digital_r |-> !pending_r)
    else $error("debounce pending during digital note");

  a_rise_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(digital_r) |-> $past(q_wr.push && q_wr.desc.op == dtno_pkg::OP_TRIGGER))
    else $error("digital note started without trigger burst");

  a_fall_expire: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(digital_r) |-> $past(q_wr.push && q_wr.desc.op == dtno_pkg::OP_EXPIRE))
    else $error("digital note ended without expiry burst");
`endif

endmodule

>>> design/dtno_queue.sv
module dtno_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  dtno_pkg::q_wr_t   q_wr,
  input  logic              pop,
  output dtno_pkg::q_stat_t q_stat,
  output dtno_pkg::desc_t   head
);

  localparam int AW = $clog2(dtno_pkg::Q_DEPTH);

  dtno_pkg::desc_t mem_r [dtno_pkg::Q_DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r;
  logic            do_push, do_pop;

  assign q_stat.full  = (count_r == (AW+1)'(dtno_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = q_wr.push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= q_wr.desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> design/dtno_back.sv
module dtno_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dtno_pkg::cfg_t    cfg,
  input  dtno_pkg::q_stat_t q_stat,
  input  dtno_pkg::desc_t   head,
  output logic              pop,
  dtno_out_if.source        out_ch
);

  logic       valid_r;
  logic [1:0] step_r;
  logic [1:0] kind_r, kind_nxt;
  logic [4:0] chan_r, chan_nxt;
  logic [6:0] num_r, num_nxt;
  logic [6:0] val_r, val_nxt;
  logic       pin_r, pin_nxt;
  logic       last_r, last_nxt;

  logic       adv;
  logic [1:0] eff;

  assign adv = !q_stat.empty && (!valid_r || out_ch.ready);
  assign pop = adv && last_nxt;

  // a trigger without a sounding analog note skips the analog note off
  assign eff = (head.op == dtno_pkg::OP_TRIGGER && !head.flag) ? step_r + 2'd1 : step_r;

  always_comb begin
    kind_nxt = dtno_pkg::KIND_ON;
    chan_nxt = cfg.analog_channel;
    num_nxt  = cfg.note_number;
    val_nxt  = cfg.note_velocity;
    pin_nxt  = 1'b0;
    last_nxt = 1'b1;
    unique case (head.op)
      dtno_pkg::OP_START: begin
        pin_nxt = head.flag;
      end
      dtno_pkg::OP_TRIGGER: begin
        case (eff)
          2'd0: begin
            kind_nxt = dtno_pkg::KIND_OFF;
            last_nxt = 1'b0;
          end
          2'd1: begin
            chan_nxt = cfg.digital_channel;
            pin_nxt  = 1'b1;
            last_nxt = 1'b0;
          end
          default: begin
            kind_nxt = dtno_pkg::KIND_CC;
            chan_nxt = cfg.cc_channel;
            num_nxt  = cfg.cc_on_number;
            val_nxt  = dtno_pkg::CC_VALUE;
            pin_nxt  = 1'b1;
          end
        endcase
      end
      dtno_pkg::OP_EXPIRE: begin
        case (eff)
          2'd0: begin
            kind_nxt = dtno_pkg::KIND_OFF;
            chan_nxt = cfg.digital_channel;
            last_nxt = 1'b0;
          end
          2'd1: begin
            kind_nxt = dtno_pkg::KIND_CC;
            chan_nxt = cfg.cc_channel;
            num_nxt  = cfg.cc_on_number + 7'd1;
            val_nxt  = dtno_pkg::CC_VALUE;
            last_nxt = !head.flag;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= '0;
    end else begin
      if (adv) begin
        valid_r <= 1'b1;
        step_r  <= last_nxt ? 2'd0 : step_r + 2'd1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r <= kind_nxt;
      chan_r <= chan_nxt;
      num_r  <= num_nxt;
      val_r  <= val_nxt;
      pin_r  <= pin_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.msg_kind      = kind_r;
  assign out_ch.msg_channel   = chan_r;
  assign out_ch.msg_number    = num_r;
  assign out_ch.msg_value     = val_r;
  assign out_ch.out_pin_level = pin_r;
  assign out_ch.last_of_run   = last_r;

`ifndef SYNTHESIS
  a_step_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != 2'd0) |-> !q_stat.empty)
    else $error("burst in progress with empty queue");
`endif

endmodule

>>> design/debounced_trigger_note_oneshot_top.sv
// Debounced trigger one-shot note sequencer. The input channel takes one transaction per
// cycle (start command or sensor poll) as long as the 4-entry burst queue has room; the
// front end updates the debounce and note timers and the note state in that same cycle.
// Each input causes zero to three messages, which the back end sends from the queue one
// per cycle while the receiver is ready, through a registered output, so one input per
// cycle is sustained unless bursts of two or three messages or receiver stalls fill the
// queue, and the output drain then sets the pace. Configuration registers are written
// through cfg_we/cfg_idx/cfg_data and must only change while no messages are outstanding.
module debounced_trigger_note_oneshot_top #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  dtno_in_if.sink                           in_ch,
  dtno_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [dtno_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [dtno_pkg::CFG_DATA_W-1:0]   cfg_data
);

  dtno_pkg::cfg_t    cfg_r;
  dtno_pkg::q_wr_t   q_wr;
  dtno_pkg::q_stat_t q_stat;
  dtno_pkg::desc_t   head;
  logic              pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.note_number      <= dtno_pkg::RST_NOTE_NUMBER;
      cfg_r.note_velocity    <= dtno_pkg::RST_NOTE_VELOCITY;
      cfg_r.analog_channel   <= dtno_pkg::RST_ANALOG_CHANNEL;
      cfg_r.digital_channel  <= dtno_pkg::RST_DIGITAL_CHANNEL;
      cfg_r.cc_on_number     <= dtno_pkg::RST_CC_ON_NUMBER;
      cfg_r.cc_channel       <= dtno_pkg::RST_CC_CHANNEL;
      cfg_r.note_duration_ms <= dtno_pkg::RST_NOTE_DURATION_MS;
      cfg_r.debounce_ms      <= dtno_pkg::RST_DEBOUNCE_MS;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dtno_pkg::REG_NOTE_NUMBER:      cfg_r.note_number      <= cfg_data[6:0];
        dtno_pkg::REG_NOTE_VELOCITY:    cfg_r.note_velocity    <= cfg_data[6:0];
        dtno_pkg::REG_ANALOG_CHANNEL:   cfg_r.analog_channel   <= cfg_data[4:0];
        dtno_pkg::REG_DIGITAL_CHANNEL:  cfg_r.digital_channel  <= cfg_data[4:0];
        dtno_pkg::REG_CC_ON_NUMBER:     cfg_r.cc_on_number     <= cfg_data[6:0];
        dtno_pkg::REG_CC_CHANNEL:       cfg_r.cc_channel       <= cfg_data[4:0];
        dtno_pkg::REG_NOTE_DURATION_MS: cfg_r.note_duration_ms <= cfg_data[15:0];
        dtno_pkg::REG_DEBOUNCE_MS:      cfg_r.debounce_ms      <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  dtno_front #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_stat (q_stat),
    .q_wr   (q_wr)
  );

  dtno_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  dtno_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

>>> test/dtno_checker.sv
module dtno_checker import dtno_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dtno_in_if                    in_ch,
  dtno_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fails,
  output int                    outstanding
);

  localparam int TIMER_W = 16;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] channel;
    logic [6:0] number;
    logic [6:0] value;
    logic       pin;
    logic       last;
  } midi_msg_t;

  cfg_t               regs;
  logic               analog_sounding;
  logic               digital_sounding;
  logic               rise_pending;
  logic               level_accepted;
  logic [TIMER_W-1:0] note_ms;
  logic [TIMER_W-1:0] rise_ms;

  midi_msg_t          burst[3];
  int                 burst_n;
  midi_msg_t          expected_msgs[$];

  // pin field reports the digital note state at the point in the burst where the message is added
  function automatic void add_msg(logic [1:0] kind, logic [4:0] ch, logic [6:0] num,
                                  logic [6:0] val);
    burst[burst_n] = '{kind, ch, num, val, digital_sounding, 1'b0};
    burst_n++;
  endfunction

  function automatic void sound_analog();
    if (!analog_sounding) begin
      add_msg(KIND_ON, regs.analog_channel, regs.note_number, regs.note_velocity);
      analog_sounding = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : monitor
    midi_msg_t got;
    midi_msg_t want;
    if (!rst_n) begin
      regs = '{note_number: RST_NOTE_NUMBER, note_velocity: RST_NOTE_VELOCITY,
               analog_channel: RST_ANALOG_CHANNEL, digital_channel: RST_DIGITAL_CHANNEL,
               cc_on_number: RST_CC_ON_NUMBER, cc_channel: RST_CC_CHANNEL,
               note_duration_ms: RST_NOTE_DURATION_MS, debounce_ms: RST_DEBOUNCE_MS};
      analog_sounding  = 1'b0;
      digital_sounding = 1'b0;
      rise_pending     = 1'b0;
      level_accepted   = 1'b0;
      note_ms          = '0;
      rise_ms          = '0;
      fails            = 0;
      expected_msgs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_NOTE_NUMBER:      regs.note_number      = cfg_data[6:0];
          REG_NOTE_VELOCITY:    regs.note_velocity    = cfg_data[6:0];
          REG_ANALOG_CHANNEL:   regs.analog_channel   = cfg_data[4:0];
          REG_DIGITAL_CHANNEL:  regs.digital_channel  = cfg_data[4:0];
          REG_CC_ON_NUMBER:     regs.cc_on_number     = cfg_data[6:0];
          REG_CC_CHANNEL:       regs.cc_channel       = cfg_data[4:0];
          REG_NOTE_DURATION_MS: regs.note_duration_ms = cfg_data[15:0];
          REG_DEBOUNCE_MS:      regs.debounce_ms      = cfg_data[15:0];
          default: ;
        endcase
      end

      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.msg_kind, out_ch.msg_channel, out_ch.msg_number, out_ch.msg_value,
                out_ch.out_pin_level, out_ch.last_of_run};
        if (expected_msgs.size() == 0) begin
          fails++;
          $display("%0t: message with none expected: kind=%0d ch=%0d num=%0d val=%0d pin=%0d last=%0d",
                   $time, got.kind, got.channel, got.number, got.value, got.pin, got.last);
        end else begin
          want = expected_msgs.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: mismatch expected kind=%0d ch=%0d num=%0d val=%0d pin=%0d last=%0d",
                     $time, want.kind, want.channel, want.number, want.value, want.pin,
                     want.last);
            $display("%0t:          actual   kind=%0d ch=%0d num=%0d val=%0d pin=%0d last=%0d",
                     $time, got.kind, got.channel, got.number, got.value, got.pin, got.last);
          end
        end
      end

      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        burst_n = 0;
        // both timers advance before anything else and stick at full scale
        if (in_ch.ms_tick) begin
          if (note_ms != TIMER_MAX) note_ms = note_ms + 1'b1;
          if (rise_ms != TIMER_MAX) rise_ms = rise_ms + 1'b1;
        end
        if (in_ch.action == ACTION_START) begin
          sound_analog();
        end else begin
          if (digital_sounding && note_ms >= regs.note_duration_ms) begin
            digital_sounding = 1'b0;
            add_msg(KIND_OFF, regs.digital_channel, regs.note_number, regs.note_velocity);
            add_msg(KIND_CC, regs.cc_channel, regs.cc_on_number + 7'd1, CC_VALUE);
            note_ms = '0;
            sound_analog();
          end
          if (!digital_sounding) begin
            if (rise_pending) begin
              if (!in_ch.pin_level) begin
                rise_pending = 1'b0;
              end else if (rise_ms >= regs.debounce_ms) begin
                rise_pending   = 1'b0;
                level_accepted = 1'b1;
                if (analog_sounding) begin
                  add_msg(KIND_OFF, regs.analog_channel, regs.note_number,
                          regs.note_velocity);
                  analog_sounding = 1'b0;
                end
                digital_sounding = 1'b1;
                add_msg(KIND_ON, regs.digital_channel, regs.note_number, regs.note_velocity);
                add_msg(KIND_CC, regs.cc_channel, regs.cc_on_number, CC_VALUE);
                note_ms = '0;
              end
            end else if (in_ch.pin_level != level_accepted) begin
              if (in_ch.pin_level) begin
                rise_pending = 1'b1;
                rise_ms      = '0;
              end else begin
                level_accepted = 1'b0;
              end
            end
          end
        end
        if (burst_n > 0) burst[burst_n-1].last = 1'b1;
        for (int i = 0; i < burst_n; i++) expected_msgs.push_back(burst[i]);
      end
    end
    outstanding = expected_msgs.size();
  end

endmodule

>>> test/tb_top.sv
module tb_top;
  import dtno_pkg::*;

  localparam logic ACTION_POLL = ~ACTION_START;
  localparam int   CYCLE_LIMIT = 800000;
  localparam int   HOLD_CYCLES = 60;
  localparam int   SAT_ITEMS   = 4;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fails;
  int                    outstanding;
  int                    cycles = 0;
  logic                  gaps_on;
  logic                  rx_hold_req;

  dtno_in_if  in_ch();
  dtno_out_if out_ch();

  debounced_trigger_note_oneshot_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  dtno_checker i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .fails       (fails),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ch.ready = 1'b0;
        rx_hold_req  = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        out_ch.ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send(input logic act, input logic lvl, input logic tick);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.action    = act;
    in_ch.pin_level = lvl;
    in_ch.ms_tick   = tick;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // stop offering and let every expected message drain
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  task automatic load_cfg(input cfg_t c);
    write_reg(REG_NOTE_NUMBER, CFG_DATA_W'(c.note_number));
    write_reg(REG_NOTE_VELOCITY, CFG_DATA_W'(c.note_velocity));
    write_reg(REG_ANALOG_CHANNEL, CFG_DATA_W'(c.analog_channel));
    write_reg(REG_DIGITAL_CHANNEL, CFG_DATA_W'(c.digital_channel));
    write_reg(REG_CC_ON_NUMBER, CFG_DATA_W'(c.cc_on_number));
    write_reg(REG_CC_CHANNEL, CFG_DATA_W'(c.cc_channel));
    write_reg(REG_NOTE_DURATION_MS, c.note_duration_ms);
    write_reg(REG_DEBOUNCE_MS, c.debounce_ms);
  endtask

  initial begin
    cfg_t rc;
    logic lvl;
    logic item_lvl;
    logic act;
    int   drain_wait;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACTION_START;
    in_ch.pin_level = 1'b0;
    in_ch.ms_tick   = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_NOTE_NUMBER;
    cfg_data        = '0;
    gaps_on         = 1'b1;
    rx_hold_req     = 1'b0;
    lvl             = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: analog note on, repeated start, aborted and restarted debounce
    send(ACTION_START, 1'b0, 1'b0);
    send(ACTION_START, 1'b1, 1'b1);
    send(ACTION_POLL, 1'b1, 1'b1);
    send(ACTION_POLL, 1'b0, 1'b1);
    send(ACTION_POLL, 1'b1, 1'b0);

    // zero durations, wrapping controller, out-of-range channels
    settle();
    rc = '{note_number: 7'd127, note_velocity: 7'd0, analog_channel: 5'd0,
           digital_channel: 5'd31, cc_on_number: 7'd127, cc_channel: 5'd17,
           note_duration_ms: 16'd0, debounce_ms: 16'd0};
    load_cfg(rc);
    send(ACTION_POLL, 1'b1, 1'b0);
    send(ACTION_START, 1'b0, 1'b0);  // start during the digital note
    send(ACTION_POLL, 1'b1, 1'b0);
    send(ACTION_POLL, 1'b0, 1'b0);
    send(ACTION_POLL, 1'b1, 1'b1);
    send(ACTION_POLL, 1'b1, 1'b0);
    send(ACTION_POLL, 1'b0, 1'b1);   // expiry followed by the pin going low

    settle();
    rc = '{note_number: 7'd0, note_velocity: 7'd127, analog_channel: 5'd16,
           digital_channel: 5'd1, cc_on_number: 7'd0, cc_channel: 5'd31,
           note_duration_ms: 16'd3, debounce_ms: 16'd2};
    load_cfg(rc);
    send(ACTION_POLL, 1'b1, 1'b1);
    send(ACTION_POLL, 1'b1, 1'b1);
    send(ACTION_POLL, 1'b1, 1'b1);
    send(ACTION_POLL, 1'b0, 1'b1);
    send(ACTION_POLL, 1'b1, 1'b1);
    send(ACTION_POLL, 1'b0, 1'b1);
    send(ACTION_START, 1'b1, 1'b0);

    // full-scale durations: ticks accumulate while nothing may fire
    settle();
    rc.note_duration_ms = 16'hFFFF;
    rc.debounce_ms      = 16'hFFFF;
    load_cfg(rc);
    gaps_on = 1'b0;
    send(ACTION_POLL, 1'b0, 1'b0);
    send(ACTION_POLL, 1'b1, 1'b0);
    repeat (SAT_ITEMS) send(ACTION_START, 1'b0, 1'b1);
    send(ACTION_POLL, 1'b1, 1'b1);
    repeat (SAT_ITEMS) send(ACTION_START, 1'b1, 1'b1);
    send(ACTION_POLL, 1'b0, 1'b1);
    gaps_on = 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      rc.note_number      = 7'($urandom_range(0, 127));
      rc.note_velocity    = 7'($urandom_range(0, 127));
      rc.analog_channel   = 5'($urandom_range(0, 31));
      rc.digital_channel  = 5'($urandom_range(0, 31));
      rc.cc_on_number     = 7'($urandom_range(0, 127));
      rc.cc_channel       = 5'($urandom_range(0, 31));
      rc.note_duration_ms = 16'($urandom_range(0, 12));
      rc.debounce_ms      = 16'($urandom_range(0, 4));
      if (ph == 1) begin
        rc.note_duration_ms = 16'd0;
        rc.debounce_ms      = 16'd0;
      end
      if (ph == 5) begin
        rc.note_number     = 7'd127;
        rc.note_velocity   = 7'd127;
        rc.analog_channel  = 5'd31;
        rc.digital_channel = 5'd0;
        rc.cc_on_number    = 7'd126;
        rc.cc_channel      = 5'd0;
      end
      load_cfg(rc);
      gaps_on = (ph != 7);

      if (ph == 1) begin
        // rising, trigger, expiry back to back while the receiver holds off
        rx_hold_req = 1'b1;
        repeat (8) begin
          send(ACTION_POLL, 1'b1, 1'($urandom_range(0, 1)));
          send(ACTION_POLL, 1'b1, 1'($urandom_range(0, 1)));
          send(ACTION_POLL, 1'b0, 1'($urandom_range(0, 1)));
        end
        settle();
      end

      repeat (45) begin
        if ($urandom_range(0, 9) == 0) lvl = ~lvl;
        item_lvl = ($urandom_range(0, 15) == 0) ? ~lvl : lvl;
        act      = ($urandom_range(0, 19) == 0) ? ACTION_START : ACTION_POLL;
        send(act, item_lvl, 1'($urandom_range(0, 1)));
      end
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    drain_wait  = 0;
    while (outstanding != 0 && drain_wait < 5000) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (8) @(negedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
